[rtl/gbnr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and control types for the go-back-N Reno sender.
// No dependencies.
package gbnr_pkg;

  localparam int SEQ_BITS      = 16;
  localparam int MAX_WINDOW    = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int RETX_CAP      = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
  localparam int RETX_BITS     = $clog2(RETX_CAP + 1);
  localparam int CWND_BITS     = 10;
  localparam int WL_BITS       = 5;
  localparam int DUP_BITS      = 8;
  localparam int SUM_BITS      = ((SEQ_BITS > CWND_BITS) ? SEQ_BITS : CWND_BITS) + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [1:0] ACT_ACK     = 2'd0;
  localparam logic [1:0] ACT_TIMEOUT = 2'd1;
  localparam logic [1:0] ACT_SESSION = 2'd2;
  localparam logic [1:0] ACT_SEND    = 2'd3;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_SEND    = 2'd1;
  localparam logic [1:0] KIND_FAST    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [1:0] TMR_LEAVE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LIMIT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_THRESH = CFG_IDX_BITS'(1);

  localparam logic [CWND_BITS-1:0] CWND_MAX     = 10'd1023;
  localparam logic [CWND_BITS-1:0] RECOV_ADD    = 10'd3;
  localparam logic [CWND_BITS-1:0] THRESH_RESET = 10'd16;
  localparam logic [WL_BITS-1:0]   WL_RESET     = 5'd10;
  localparam logic [DUP_BITS-1:0]  DUP_MAX      = 8'd255;
  localparam logic [DUP_BITS-1:0]  DUP_TRIGGER  = 8'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic emit_retx;
  } gbnr_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       out_free;
    logic       retx_last;
  } gbnr_stat_t;

endpackage

[rtl/gbnr_ifs.sv]
`timescale 1ns / 1ps
// Handshake channels of the sender: request in, result out, configuration write.
// Depends on gbnr_pkg.
interface gbnr_req_if import gbnr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [SEQ_BITS-1:0] ack_number;
  logic                checksum_ok;
  logic                fin_flag;
  logic [SEQ_BITS-1:0] packet_count;

  modport source (output valid, action, ack_number, checksum_ok, fin_flag, packet_count,
                  input ready);
  modport sink (input valid, action, ack_number, checksum_ok, fin_flag, packet_count,
                output ready);
endinterface

interface gbnr_res_if import gbnr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [SEQ_BITS-1:0]  send_seq;
  logic [1:0]           timer_action;
  logic                 finished;
  logic                 last_of_run;
  logic [CWND_BITS-1:0] window_size;
  logic [CWND_BITS-1:0] threshold;
  logic [1:0]           phase;

  modport source (output valid, result_kind, send_seq, timer_action, finished, last_of_run,
                  window_size, threshold, phase, input ready);
  modport sink (input valid, result_kind, send_seq, timer_action, finished, last_of_run,
                window_size, threshold, phase, output ready);
endinterface

interface gbnr_cfg_if import gbnr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/gbnr_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the sender: accepts a request, runs its step, walks timeout resends.
// Depends on gbnr_pkg.
module gbnr_ctrl import gbnr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  gbnr_stat_t stat,
  output gbnr_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RETX = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    req_ready     = 1'b0;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = (stat.act == ACT_TIMEOUT) ? S_RETX : S_IDLE;
        end
      end
      S_RETX: begin
        if (stat.out_free) begin
          cmd.emit_retx = 1'b1;
          if (stat.retx_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.capture, cmd.exec, cmd.emit_retx}) <= 1)
    else $error("more than one datapath command in a cycle");

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req_ready)
    else $error("new request taken before the previous step ran");

  a_timeout_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && stat.act == ACT_TIMEOUT) |=> state == S_RETX)
    else $error("timeout step did not start resends");

endmodule

[rtl/gbnr_dp.sv]
`timescale 1ns / 1ps
// Datapath of the sender: window and Reno state, step logic, resend walker, result register.
// Depends on gbnr_pkg.
module gbnr_dp import gbnr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  gbnr_cmd_t                cmd,
  output gbnr_stat_t               stat,
  input  logic [1:0]               action,
  input  logic [SEQ_BITS-1:0]      ack_number,
  input  logic                     checksum_ok,
  input  logic                     fin_flag,
  input  logic [SEQ_BITS-1:0]      packet_count,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [1:0]               result_kind,
  output logic [SEQ_BITS-1:0]      send_seq,
  output logic [1:0]               timer_action,
  output logic                     finished,
  output logic                     last_of_run,
  output logic [CWND_BITS-1:0]     window_size,
  output logic [CWND_BITS-1:0]     threshold,
  output logic [1:0]               phase
);

  logic [1:0]           act_q;
  logic [SEQ_BITS-1:0]  ack_q;
  logic                 ck_q;
  logic                 fin_q;
  logic [SEQ_BITS-1:0]  cnt_q;

  logic [WL_BITS-1:0]   window_limit;
  logic [SEQ_BITS-1:0]  window_base;
  logic [SEQ_BITS-1:0]  next_seq;
  logic [SEQ_BITS-1:0]  queued_total;
  logic [CWND_BITS-1:0] cong_window;
  logic [CWND_BITS-1:0] slow_threshold;
  logic [DUP_BITS-1:0]  dup_count;
  logic [CWND_BITS-1:0] growth_count;
  logic [1:0]           cong_phase;
  logic [SEQ_BITS-1:0]  retx_seq;
  logic [RETX_BITS-1:0] retx_left;

  logic [SEQ_BITS-1:0]  base_next;
  logic [SEQ_BITS-1:0]  nseq_next;
  logic [SEQ_BITS-1:0]  queued_next;
  logic [CWND_BITS-1:0] cwnd_next;
  logic [CWND_BITS-1:0] sst_next;
  logic [DUP_BITS-1:0]  dup_next;
  logic [CWND_BITS-1:0] growth_next;
  logic [1:0]           phase_next;
  logic [RETX_BITS-1:0] retx_n;
  logic [1:0]           r_kind;
  logic [SEQ_BITS-1:0]  r_seq;
  logic [1:0]           r_timer;
  logic                 r_fin;

  logic [SEQ_BITS:0]    ack_inc;
  logic                 fresh;
  logic [CWND_BITS-1:0] cwnd_inc;
  logic [WL_BITS-1:0]   lim;
  logic [SUM_BITS-1:0]  lim_edge;
  logic [SUM_BITS-1:0]  cwnd_edge;
  logic [SEQ_BITS-1:0]  gap;
  logic                 load;

  assign cwnd_inc  = (cong_window < CWND_MAX) ? cong_window + 1'b1 : CWND_MAX;
  assign ack_inc   = {1'b0, ack_q} + 1'b1;
  assign fresh     = ack_inc > {1'b0, window_base};
  assign lim       = (32'(window_limit) > MAX_WINDOW) ? MAX_WINDOW[WL_BITS-1:0] : window_limit;
  assign lim_edge  = SUM_BITS'(window_base) + SUM_BITS'(lim);
  assign cwnd_edge = SUM_BITS'(window_base) + SUM_BITS'(cong_window);
  assign gap       = next_seq - window_base;

  always_comb begin
    base_next   = window_base;
    nseq_next   = next_seq;
    queued_next = queued_total;
    cwnd_next   = cong_window;
    sst_next    = slow_threshold;
    dup_next    = dup_count;
    growth_next = growth_count;
    phase_next  = cong_phase;
    retx_n      = RETX_BITS'(1);
    r_kind      = KIND_STATUS;
    r_seq       = '0;
    r_timer     = TMR_LEAVE;
    r_fin       = 1'b0;
    case (act_q)
      ACT_ACK: begin
        if (ck_q && fin_q) begin
          r_timer = TMR_STOP;
          r_fin   = 1'b1;
        end else if (ck_q) begin
          base_next = ack_inc[SEQ_BITS-1:0];
          if (base_next == next_seq) begin
            r_timer = TMR_STOP;
            r_fin   = (next_seq >= queued_total);
          end else begin
            r_timer = TMR_START;
          end
          if (cong_phase == PH_SLOW || cong_phase == PH_AVOID) begin
            if (fresh) begin
              if (cong_phase == PH_SLOW) begin
                cwnd_next = cwnd_inc;
                if (cwnd_inc >= slow_threshold) phase_next = PH_AVOID;
              end else begin
                growth_next = (growth_count < CWND_MAX) ? growth_count + 1'b1 : CWND_MAX;
                if (growth_next >= cong_window) begin
                  cwnd_next   = cwnd_inc;
                  growth_next = '0;
                end
              end
              dup_next = '0;
            end else if (dup_count < DUP_MAX) begin
              dup_next = dup_count + 1'b1;
            end
            if (dup_next >= DUP_TRIGGER) begin
              sst_next   = cwnd_next >> 1;
              cwnd_next  = sst_next + RECOV_ADD;
              phase_next = PH_RECOV;
              r_kind     = KIND_FAST;
              r_seq      = base_next;
            end
          end else if (cong_phase == PH_RECOV) begin
            if (fresh) begin
              cwnd_next  = slow_threshold;
              dup_next   = '0;
              phase_next = PH_AVOID;
            end else begin
              cwnd_next = cwnd_inc;
            end
          end
        end
      end
      ACT_TIMEOUT: begin
        sst_next   = cong_window >> 1;
        cwnd_next  = CWND_BITS'(1);
        dup_next   = '0;
        phase_next = PH_SLOW;
        if (next_seq > window_base) begin
          retx_n = (32'(gap) > RETX_CAP) ? RETX_BITS'(RETX_CAP) : gap[RETX_BITS-1:0];
        end
      end
      ACT_SESSION: begin
        base_next   = '0;
        nseq_next   = '0;
        queued_next = cnt_q;
      end
      ACT_SEND: begin
        if (SUM_BITS'(next_seq) < lim_edge && SUM_BITS'(next_seq) < cwnd_edge &&
            next_seq < queued_total) begin
          r_kind    = KIND_SEND;
          r_seq     = next_seq;
          r_timer   = (window_base == next_seq) ? TMR_START : TMR_LEAVE;
          nseq_next = next_seq + 1'b1;
        end
      end
      default: r_kind = KIND_STATUS;
    endcase
  end

  assign load = (cmd.exec && act_q != ACT_TIMEOUT) || cmd.emit_retx;

  assign stat.act       = act_q;
  assign stat.out_free  = !res_valid || res_ready;
  assign stat.retx_last = (retx_left == RETX_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      ack_q <= ack_number;
      ck_q  <= checksum_ok;
      fin_q <= fin_flag;
      cnt_q <= packet_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit   <= WL_RESET;
      window_base    <= '0;
      next_seq       <= '0;
      queued_total   <= '0;
      cong_window    <= CWND_BITS'(1);
      slow_threshold <= THRESH_RESET;
      dup_count      <= '0;
      growth_count   <= '0;
      cong_phase     <= PH_SLOW;
      retx_left      <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == CFG_WINDOW_LIMIT) begin
        window_limit <= cfg_data[WL_BITS-1:0];
      end
      if (cfg_write && cfg_index == CFG_START_THRESH) begin
        slow_threshold <= cfg_data[CWND_BITS-1:0];
      end
      if (cmd.exec) begin
        window_base    <= base_next;
        next_seq       <= nseq_next;
        queued_total   <= queued_next;
        cong_window    <= cwnd_next;
        slow_threshold <= sst_next;
        dup_count      <= dup_next;
        growth_count   <= growth_next;
        cong_phase     <= phase_next;
        if (act_q == ACT_TIMEOUT) retx_left <= retx_n;
      end
      if (cmd.emit_retx) retx_left <= retx_left - 1'b1;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && act_q == ACT_TIMEOUT) retx_seq <= window_base;
    if (cmd.emit_retx) retx_seq <= retx_seq + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_retx) begin
      result_kind  <= KIND_TIMEOUT;
      send_seq     <= retx_seq;
      timer_action <= TMR_START;
      finished     <= 1'b0;
      last_of_run  <= (retx_left == RETX_BITS'(1));
      window_size  <= cong_window;
      threshold    <= slow_threshold;
      phase        <= cong_phase;
    end else if (load) begin
      result_kind  <= r_kind;
      send_seq     <= r_seq;
      timer_action <= r_timer;
      finished     <= r_fin;
      last_of_run  <= 1'b1;
      window_size  <= cwnd_next;
      threshold    <= sst_next;
      phase        <= phase_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!res_valid || res_ready))
    else $error("result register overwritten before it was taken");

  a_retx_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && act_q == ACT_TIMEOUT) |=>
      (retx_left != '0 && 32'(retx_left) <= RETX_CAP))
    else $error("resend count out of range");

  a_retx_live: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_retx |-> retx_left != '0)
    else $error("resend issued with no resends left");

endmodule

[rtl/gbn_sender_reno_window_core.sv]
`timescale 1ns / 1ps
// Top level of the go-back-N sender window with Reno congestion control.
// Depends on gbnr_pkg, gbnr_ifs, gbnr_ctrl and gbnr_dp.
//
// Channels: req carries one event (ack, timer expiry, new session, send chance);
// res carries the results it causes, the last one flagged by last_of_run; cfg
// writes window_limit (index 0) or start_threshold (index 1, also loads the
// threshold at once). cfg is always ready; it must be written only while idle,
// a rule on the user that the block does not enforce.
// Sequence: a request is captured while idle and its step runs once the result
// register is free; an ack, session load or send chance then yields one result,
// registered when its step runs. A timer expiry runs its step and then issues
// one resend a cycle while res is not stalled, 1 to 16 of them. The result register
// is the only buffer between the step logic and the res channel.
//
// Reset: base, next sequence and queue count clear, window goes to 1, threshold
// to 16, phase to slow start, window_limit to 10; no result is pending.
// When res stalls, the step or resend waiting on the result register holds and
// req stays low until the sequence can move again.
module gbn_sender_reno_window_core import gbnr_pkg::*; (
  input  logic clk,
  input  logic rst,
  gbnr_req_if.sink   req,
  gbnr_res_if.source res,
  gbnr_cfg_if.sink   cfg
);

  gbnr_cmd_t  cmd;
  gbnr_stat_t stat;

  assign cfg.ready = 1'b1;

  gbnr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbnr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (req.action),
    .ack_number   (req.ack_number),
    .checksum_ok  (req.checksum_ok),
    .fin_flag     (req.fin_flag),
    .packet_count (req.packet_count),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .result_kind  (res.result_kind),
    .send_seq     (res.send_seq),
    .timer_action (res.timer_action),
    .finished     (res.finished),
    .last_of_run  (res.last_of_run),
    .window_size  (res.window_size),
    .threshold    (res.threshold),
    .phase        (res.phase)
  );

endmodule

[verif/gbnr_window_compare.sv]
`timescale 1ns / 1ps
// Result predictor and comparator for the go-back-N Reno sender window.
// Watches the request, result and configuration channels; depends on gbnr_pkg and gbnr_ifs.
module gbnr_window_compare import gbnr_pkg::*; (
  input  logic clk,
  input  logic rst,
  gbnr_req_if  req,
  gbnr_res_if  res,
  gbnr_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [1:0]           kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [1:0]           tmr;
    logic                 fin;
    logic                 last;
    logic [CWND_BITS-1:0] wnd;
    logic [CWND_BITS-1:0] thr;
    logic [1:0]           ph;
  } sender_result_t;

  logic [SEQ_BITS-1:0]  base;
  logic [SEQ_BITS-1:0]  next_seq;
  logic [SEQ_BITS-1:0]  queued;
  logic [CWND_BITS-1:0] cwnd;
  logic [CWND_BITS-1:0] ssthresh;
  logic [CWND_BITS-1:0] growth;
  logic [DUP_BITS-1:0]  dups;
  logic [1:0]           phase_now;
  logic [WL_BITS-1:0]   wlimit;
  sender_result_t       expected_q[$];

  function automatic logic [CWND_BITS-1:0] bump(input logic [CWND_BITS-1:0] v);
    return (v < CWND_MAX) ? v + 1'b1 : CWND_MAX;
  endfunction

  function automatic void queue_result(input logic [1:0] kind, input logic [SEQ_BITS-1:0] seq,
                                       input logic [1:0] tmr, input logic fin, input logic last);
    sender_result_t r;
    r.kind = kind;
    r.seq  = seq;
    r.tmr  = tmr;
    r.fin  = fin;
    r.last = last;
    r.wnd  = cwnd;
    r.thr  = ssthresh;
    r.ph   = phase_now;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic string show(input sender_result_t r);
    return $sformatf("kind=%0d seq=%0h timer=%0d fin=%0b last=%0b cwnd=%0d ssth=%0d phase=%0d",
                     r.kind, r.seq, r.tmr, r.fin, r.last, r.wnd, r.thr, r.ph);
  endfunction

  function automatic void predict_request(input logic [1:0] act, input logic [SEQ_BITS-1:0] ack,
                                          input logic ck, input logic fin,
                                          input logic [SEQ_BITS-1:0] count);
    logic [SEQ_BITS:0]   ack_next;
    logic                fresh;
    logic                done;
    logic [1:0]          kind;
    logic [1:0]          tmr;
    logic [SEQ_BITS-1:0] seq;
    int unsigned         n;
    int unsigned         lim;
    int unsigned         b;
    case (act)
      ACT_ACK: begin
        if (!ck) begin
          queue_result(KIND_STATUS, '0, TMR_LEAVE, 1'b0, 1'b1);
        end else if (fin) begin
          queue_result(KIND_STATUS, '0, TMR_STOP, 1'b1, 1'b1);
        end else begin
          ack_next = {1'b0, ack} + 1'b1;
          fresh = ack_next > {1'b0, base};
          base = ack_next[SEQ_BITS-1:0];
          tmr = (base == next_seq) ? TMR_STOP : TMR_START;
          done = (base == next_seq) && (next_seq >= queued);
          kind = KIND_STATUS;
          seq = '0;
          if (phase_now == PH_SLOW || phase_now == PH_AVOID) begin
            if (fresh) begin
              if (phase_now == PH_SLOW) begin
                cwnd = bump(cwnd);
                if (cwnd >= ssthresh) phase_now = PH_AVOID;
              end else begin
                growth = bump(growth);
                if (growth >= cwnd) begin
                  cwnd = bump(cwnd);
                  growth = '0;
                end
              end
              dups = '0;
            end else if (dups < DUP_MAX) begin
              dups++;
            end
            if (dups >= DUP_TRIGGER) begin
              ssthresh = cwnd >> 1;
              cwnd = ssthresh + RECOV_ADD;
              phase_now = PH_RECOV;
              kind = KIND_FAST;
              seq = base;
            end
          end else if (phase_now == PH_RECOV) begin
            if (fresh) begin
              cwnd = ssthresh;
              dups = '0;
              phase_now = PH_AVOID;
            end else begin
              cwnd = bump(cwnd);
            end
          end
          queue_result(kind, seq, tmr, done, 1'b1);
        end
      end
      ACT_TIMEOUT: begin
        ssthresh = cwnd >> 1;
        cwnd = CWND_BITS'(1);
        dups = '0;
        phase_now = PH_SLOW;
        n = (next_seq > base) ? 32'(next_seq - base) : 1;
        if (n > RETX_CAP) n = RETX_CAP;
        for (int unsigned i = 0; i < n; i++)
          queue_result(KIND_TIMEOUT, base + SEQ_BITS'(i), TMR_START, 1'b0, i + 1 == n);
      end
      ACT_SESSION: begin
        base = '0;
        next_seq = '0;
        queued = count;
        queue_result(KIND_STATUS, '0, TMR_LEAVE, 1'b0, 1'b1);
      end
      default: begin
        lim = (32'(wlimit) > MAX_WINDOW) ? MAX_WINDOW : 32'(wlimit);
        b = 32'(base);
        if (32'(next_seq) < b + lim && 32'(next_seq) < b + 32'(cwnd) && next_seq < queued) begin
          tmr = (base == next_seq) ? TMR_START : TMR_LEAVE;
          seq = next_seq;
          next_seq = next_seq + 1'b1;
          queue_result(KIND_SEND, seq, tmr, 1'b0, 1'b1);
        end else begin
          queue_result(KIND_STATUS, '0, TMR_LEAVE, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    sender_result_t got;
    sender_result_t want;
    if (rst) begin
      base = '0;
      next_seq = '0;
      queued = '0;
      cwnd = CWND_BITS'(1);
      ssthresh = THRESH_RESET;
      growth = '0;
      dups = '0;
      phase_now = PH_SLOW;
      wlimit = WL_RESET;
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        got.kind = res.result_kind;
        got.seq  = res.send_seq;
        got.tmr  = res.timer_action;
        got.fin  = res.finished;
        got.last = res.last_of_run;
        got.wnd  = res.window_size;
        got.thr  = res.threshold;
        got.ph   = res.phase;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("%t unexpected result: %s", $realtime, show(got));
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind || got.seq !== want.seq || got.tmr !== want.tmr ||
              got.fin !== want.fin || got.last !== want.last || got.wnd !== want.wnd ||
              got.thr !== want.thr || got.ph !== want.ph) begin
            if (mismatches < 10)
              $display("%t result differs\n  expected %s\n  actual   %s",
                       $realtime, show(want), show(got));
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_WINDOW_LIMIT) wlimit = cfg.data[WL_BITS-1:0];
        else if (cfg.index == CFG_START_THRESH) ssthresh = cfg.data;
      end
      if (req.valid && req.ready)
        predict_request(req.action, req.ack_number, req.checksum_ok, req.fin_flag,
                        req.packet_count);
    end
    outstanding <= expected_q.size();
  end

endmodule

[verif/tb_gbn_sender_reno_window_core.sv]
`timescale 1ns / 1ps
// Testbench top for gbn_sender_reno_window_core: clock, reset, request and configuration
// stimulus, result back-pressure and verdict. Depends on gbnr_pkg, gbnr_ifs, gbnr_window_compare and the DUT.
module tb_gbn_sender_reno_window_core;
  import gbnr_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SEGMENT_ITEMS   = 32;
  localparam int SATURATION_DUPS = 10;

  logic                clk;
  logic                rst;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  mismatches;
  int                  outstanding;
  int                  dup_run;
  logic [SEQ_BITS-1:0] ack_mark;
  logic [SEQ_BITS-1:0] last_sent = '0;

  gbnr_req_if req ();
  gbnr_res_if res ();
  gbnr_cfg_if cfg ();

  gbn_sender_reno_window_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  gbnr_window_compare window_compare (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    res.ready <= rst ? 1'b1 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (res.valid && res.ready && res.result_kind == KIND_SEND)
      last_sent <= res.send_seq + 1'b1;
  end

  task automatic issue(input logic [1:0] act, input logic [SEQ_BITS-1:0] ack, input logic ck,
                       input logic fin, input logic [SEQ_BITS-1:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.ack_number   <= ack;
    req.checksum_ok  <= ck;
    req.fin_flag     <= fin;
    req.packet_count <= count;
    do @(posedge clk); while (!req.ready);
    if (act == ACT_SESSION) ack_mark = '0;
    else if (act == ACT_ACK && ck && !fin) ack_mark = ack + 1'b1;
  endtask

  task automatic drain(input int holdoff);
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (holdoff) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] wl_data,
                            input logic [CFG_DATA_BITS-1:0] thr_data);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_WINDOW_LIMIT;
    cfg.data  <= wl_data;
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= CFG_START_THRESH;
    cfg.data  <= thr_data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Bias toward in-window acks and duplicate runs; keep some noise acks.
  task automatic random_item();
    int                  r;
    logic [1:0]          act;
    logic [SEQ_BITS-1:0] ack;
    logic [SEQ_BITS-1:0] count;
    logic                ck;
    logic                fin;
    act   = ACT_ACK;
    ack   = SEQ_BITS'($urandom);
    count = SEQ_BITS'($urandom);
    ck    = 1'($urandom);
    fin   = 1'($urandom);
    r     = int'($urandom_range(0, 99));
    if (dup_run > 0) begin
      dup_run--;
      ack = ack_mark - 1'b1;
      ck  = 1'b1;
      fin = 1'b0;
    end else if (r < 30) begin
      act = ACT_SEND;
    end else if (r < 60) begin
      ck  = 1'b1;
      fin = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        dup_run = int'($urandom_range(1, 4));
        ack = ack_mark - 1'b1;
      end else if (last_sent > ack_mark) begin
        ack = SEQ_BITS'($urandom_range(32'(ack_mark), 32'(last_sent) - 1));
      end else begin
        ack = ack_mark;
      end
    end else if (r < 68) begin
      act = ACT_TIMEOUT;
    end else if (r < 72) begin
      act = ACT_SESSION;
      case ($urandom_range(0, 9))
        0:       count = '0;
        1:       count = SEQ_BITS'($urandom);
        default: count = SEQ_BITS'($urandom_range(1, 40));
      endcase
    end else if (r >= 92) begin
      act = ACT_SEND;
    end
    issue(act, ack, ck, fin, count);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (res.valid && res.ready) ||
          (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("gbn_sender_reno_window_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [WL_BITS-1:0]       wl;
    logic [4:0]               hi;
    logic [CFG_DATA_BITS-1:0] thr;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.action       <= ACT_ACK;
    req.ack_number   <= '0;
    req.checksum_ok  <= 1'b0;
    req.fin_flag     <= 1'b0;
    req.packet_count <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CFG_WINDOW_LIMIT;
    cfg.data         <= '0;
    send_idle_pct    <= 24;
    recv_idle_pct    <= 58;
    ack_mark = '0;
    dup_run  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: nothing queued, bad checksum, FIN, then a short session
    issue(ACT_SEND,    16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
    issue(ACT_ACK,     16'hFFFF, 1'b0, 1'b1, 16'hAAAA);
    issue(ACT_ACK,     16'h5555, 1'b1, 1'b1, 16'h0000);
    issue(ACT_SESSION, 16'hAAAA, 1'b0, 1'b1, 16'd6);
    issue(ACT_SEND,    16'h0000, 1'b0, 1'b0, 16'h5555);
    issue(ACT_SEND,    16'h0000, 1'b0, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd0,    1'b1, 1'b0, 16'h0000);
    issue(ACT_SEND,    16'h0000, 1'b1, 1'b0, 16'h0000);
    issue(ACT_SEND,    16'h0000, 1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd1,    1'b1, 1'b0, 16'h0000);
    // three duplicates, one more inside recovery, then a fresh ack
    issue(ACT_ACK,     16'd1,    1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd1,    1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd1,    1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd1,    1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd2,    1'b1, 1'b0, 16'h0000);
    issue(ACT_SEND,    16'h0000, 1'b0, 1'b0, 16'h0000);
    issue(ACT_SEND,    16'h0000, 1'b0, 1'b0, 16'h0000);
    issue(ACT_SEND,    16'h0000, 1'b0, 1'b0, 16'h0000);
    issue(ACT_TIMEOUT, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
    // backward ack, wrapping ack, empty and full sessions
    issue(ACT_ACK,     16'd0,    1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'hFFFF, 1'b1, 1'b0, 16'h0000);
    issue(ACT_SESSION, 16'h0000, 1'b0, 1'b0, 16'd0);
    issue(ACT_ACK,     16'hFFFF, 1'b1, 1'b0, 16'h0000);
    issue(ACT_SESSION, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
    issue(ACT_TIMEOUT, 16'h0000, 1'b0, 1'b0, 16'h0000);

    for (int seg = 0; seg < 6; seg++) begin
      drain(4);
      if (seg == 2) begin
        send_idle_pct <= 58;
        recv_idle_pct <= 24;
      end else if (seg == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      case (seg)
        0: begin wl = 5'd16; thr = 10'd1023; end
        1: begin wl = 5'd1;  thr = 10'd0;    end
        2: begin wl = 5'd31; thr = 10'd8;    end
        3: begin wl = 5'd0;  thr = 10'd3;    end
        default: begin
          wl  = WL_BITS'($urandom);
          thr = CFG_DATA_BITS'($urandom);
        end
      endcase
      hi = 5'($urandom);
      set_config({hi, wl}, thr);
      repeat (SEGMENT_ITEMS) begin
        random_item();
        if ($urandom_range(0, 49) == 0) drain(4);
      end
    end

    // hold recovery on a run of duplicates, then leave it
    drain(4);
    issue(ACT_SESSION, 16'h0000, 1'b0, 1'b0, 16'd100);
    issue(ACT_TIMEOUT, 16'h0000, 1'b0, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd0,    1'b1, 1'b0, 16'h0000);
    repeat (SATURATION_DUPS) issue(ACT_ACK, 16'd0, 1'b1, 1'b0, 16'h0000);
    issue(ACT_ACK,     16'd50,   1'b1, 1'b0, 16'h0000);

    drain(20);
    if (mismatches == 0)
      $display("gbn_sender_reno_window_core: match");
    else
      $display("gbn_sender_reno_window_core: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/gbnr_pkg.sv
rtl/gbnr_ifs.sv
rtl/gbnr_ctrl.sv
rtl/gbnr_dp.sv
rtl/gbn_sender_reno_window_core.sv
verif/gbnr_window_compare.sv
verif/tb_gbn_sender_reno_window_core.sv
